FILE: hdl/dgrc_pkg.sv
package dgrc_pkg;

  localparam int MAP_SIDE  = 64;
  localparam int MAP_BITS  = 6;
  localparam int MAP_CELLS = MAP_SIDE * MAP_SIDE;
  localparam int FRAC_BITS = 10;
  localparam int MAX_STEPS = 2 * MAP_SIDE + 4;

  localparam logic [10:0] ONE_CELL  = 11'd1024;
  localparam logic [14:0] TRIG_ONE  = 15'd16384;
  localparam logic [46:0] DELTA_SAT = 47'h4000_0000_0000;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_MAP_WIDTH   = 2'd0;
  localparam logic [1:0] REG_MAP_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_DEPTH_LIMIT = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_HIT     = 2'd0;
  localparam logic [1:0] KIND_LIMITED = 2'd1;
  localparam logic [1:0] KIND_INSIDE  = 2'd2;

  typedef logic [14:0] trig_tab_t [256];

  // First-quadrant sine or cosine of r * (pi/2) / 2^30, Q14, Taylor series in Q30
  function automatic logic [14:0] quarter_trig(logic [63:0] r, bit want_cos);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] ts;
    logic [63:0] tc;
    longint      ss;
    longint      cs;
    longint      v;
    logic [63:0] q;
    x  = (r * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    ts = x;
    tc = 64'd1 << 30;
    ss = longint'(x);
    cs = longint'(tc);
    for (int k = 1; k <= 7; k++) begin
      ts = ((ts * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      tc = ((tc * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        ss = ss - longint'(ts);
        cs = cs - longint'(tc);
      end else begin
        ss = ss + longint'(ts);
        cs = cs + longint'(tc);
      end
    end
    v = want_cos ? cs : ss;
    if (v <= 0) begin
      return 15'd0;
    end
    q = (64'(v) + 64'd32768) >> 16;
    if (q > 64'(TRIG_ONE)) begin
      q = 64'(TRIG_ONE);
    end
    return q[14:0];
  endfunction

  function automatic trig_tab_t build_tab(bit want_cos);
    trig_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = quarter_trig(64'(i) << 22, want_cos);
    end
    return t;
  endfunction

  localparam trig_tab_t SIN_TAB = build_tab(1'b0);
  localparam trig_tab_t COS_TAB = build_tab(1'b1);

endpackage

FILE: hdl/dgrc_ram.sv
module dgrc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wen,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/dda_grid_ray_cast.sv
// Grid ray caster: a 64x64 one-bit wall map is filled by write items (tuser 0) and
// cast items (tuser 1) march a ray from the player position through the grid one
// cell at a time and return the perpendicular wall distance (Q6.10, clamped to
// depth_limit), the side hit and a result kind. After reset the map is cleared by a
// pass over all 4096 cells during which no item is accepted. A write item is stored
// as it is accepted. A cast item runs the start cell checks, then the two direction
// reciprocals (one shared 32-step radix-2 divider), the initial side distances,
// then per grid cell crossed a step, a bounds check and a map read and compare,
// and last the final distance division on the same divider and the output load.
// The block takes one item at a time; a result waits in the output register until
// taken.
module dda_grid_ray_cast (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,  // cell_col, cell_row, cell_is_wall, player_x, player_y,
                                // ray_angle, zero pad
  input  logic        s_tuser,  // op
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // distance
  output logic [2:0]  m_tuser   // hit_side, hit_kind
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PCHK, S_PWALL, S_DIVX, S_DIVY, S_SIDEX, S_SIDEY,
    S_STEP, S_BCHK, S_WCHK, S_DIVP, S_OUT
  } state_t;

  state_t state;

  logic [6:0]  map_width;
  logic [6:0]  map_height;
  logic [15:0] depth_limit;

  logic [11:0] clr_addr;
  logic [15:0] px, py;
  logic [9:0]  angle;
  logic signed [7:0] mx, my;
  logic [7:0]  step_cnt;
  logic        side;
  logic [14:0] adx, ady;
  logic        negx, negy;
  logic [46:0] ddx, ddy;
  logic [55:0] sdx, sdy;

  logic [31:0] div_q;
  logic [15:0] div_r;
  logic [14:0] div_d;
  logic [4:0]  div_cnt;

  logic [15:0] res_dist;
  logic        res_side;
  logic [1:0]  res_kind;

  // Configuration port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    unique case (paddr[3:2])
      dgrc_pkg::REG_MAP_WIDTH:   prdata = {25'd0, map_width};
      dgrc_pkg::REG_MAP_HEIGHT:  prdata = {25'd0, map_height};
      dgrc_pkg::REG_DEPTH_LIMIT: prdata = {16'd0, depth_limit};
      default:                   prdata = 32'd0;
    endcase
  end

  // Effective map size
  logic [6:0] w_eff, h_eff;
  assign w_eff = (map_width > 7'(dgrc_pkg::MAP_SIDE)) ? 7'(dgrc_pkg::MAP_SIDE) : map_width;
  assign h_eff = (map_height > 7'(dgrc_pkg::MAP_SIDE)) ? 7'(dgrc_pkg::MAP_SIDE) : map_height;

  // Input accept and map access
  logic accept;
  logic wall_rd;
  logic ram_wen;
  logic [11:0] ram_waddr;
  logic ram_wdata;
  assign s_tready = (state == S_IDLE);
  assign accept = s_tvalid & s_tready;
  assign ram_wen = (state == S_CLEAR) || (accept && !s_tuser);
  assign ram_waddr = (state == S_CLEAR) ? clr_addr : {s_tdata[11:6], s_tdata[5:0]};
  assign ram_wdata = (state == S_CLEAR) ? 1'b0 : s_tdata[12];

  dgrc_ram #(.WIDTH(1), .DEPTH(dgrc_pkg::MAP_CELLS)) u_map (
    .clk   (clk),
    .wen   (ram_wen),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr ({my[5:0], mx[5:0]}),
    .rdata (wall_rd)
  );

  // Direction from the quarter-wave tables
  logic [14:0] tc, ts;
  logic [14:0] dirx_mag, diry_mag;
  logic        dirx_neg, diry_neg;
  always_comb begin
    tc = dgrc_pkg::COS_TAB[angle[7:0]];
    ts = dgrc_pkg::SIN_TAB[angle[7:0]];
    unique case (angle[9:8])
      2'd0: begin dirx_mag = tc; dirx_neg = 1'b0; diry_mag = ts; diry_neg = 1'b0; end
      2'd1: begin dirx_mag = ts; dirx_neg = 1'b1; diry_mag = tc; diry_neg = 1'b0; end
      2'd2: begin dirx_mag = tc; dirx_neg = 1'b1; diry_mag = ts; diry_neg = 1'b1; end
      default: begin dirx_mag = ts; dirx_neg = 1'b0; diry_mag = tc; diry_neg = 1'b1; end
    endcase
  end

  // Shared divider step: restoring, one quotient bit per cycle
  logic [16:0] rem_sh;
  logic        div_ge;
  logic [16:0] rem_sub;
  logic [31:0] q_final;
  assign rem_sh  = {div_r, div_q[31]};
  assign div_ge  = rem_sh >= {2'b0, div_d};
  assign rem_sub = rem_sh - {2'b0, div_d};
  assign q_final = {div_q[30:0], div_ge};

  // Shared multiplier for the initial side distances
  logic [10:0] frac_x, frac_y, mul_frac;
  logic [46:0] mul_delta;
  logic [41:0] mul_prod;
  logic [55:0] side_init;
  assign frac_x = negx ? {1'b0, px[9:0]} : dgrc_pkg::ONE_CELL - {1'b0, px[9:0]};
  assign frac_y = negy ? {1'b0, py[9:0]} : dgrc_pkg::ONE_CELL - {1'b0, py[9:0]};
  assign mul_frac  = (state == S_SIDEY) ? frac_y : frac_x;
  assign mul_delta = (state == S_SIDEY) ? ddy : ddx;
  assign mul_prod  = mul_frac * mul_delta[30:0];
  assign side_init = (mul_delta == dgrc_pkg::DELTA_SAT) ? {9'd0, mul_frac, 36'd0}
                                                       : {24'd0, mul_prod[41:10]};

  // Bounds and hit-side numerator
  logic out_of_map;
  logic signed [19:0] snum;
  logic [19:0] num;
  logic [14:0] adir;
  assign out_of_map = mx[7] || my[7] || (mx[6:0] >= w_eff) || (my[6:0] >= h_eff);
  always_comb begin
    if (side) begin
      snum = ($signed(20'(my)) <<< 10) - $signed({4'd0, py})
             + (negy ? 20'sd1024 : 20'sd0);
      adir = ady;
    end else begin
      snum = ($signed(20'(mx)) <<< 10) - $signed({4'd0, px})
             + (negx ? 20'sd1024 : 20'sd0);
      adir = adx;
    end
    num = snum[19] ? 20'(-snum) : 20'(snum);
  end

  // Sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      map_width   <= 7'd64;
      map_height  <= 7'd64;
      depth_limit <= 16'd16384;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[3:2])
          dgrc_pkg::REG_MAP_WIDTH:   map_width   <= pwdata[6:0];
          dgrc_pkg::REG_MAP_HEIGHT:  map_height  <= pwdata[6:0];
          dgrc_pkg::REG_DEPTH_LIMIT: depth_limit <= pwdata[15:0];
          default: ;
        endcase
      end
      // drop the result once taken unless a new one is loaded
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 12'd1;
          if (clr_addr == 12'(dgrc_pkg::MAP_CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept && s_tuser) begin
            px    <= s_tdata[28:13];
            py    <= s_tdata[44:29];
            angle <= s_tdata[54:45];
            mx    <= {2'b0, s_tdata[28:23]};
            my    <= {2'b0, s_tdata[44:39]};
            state <= S_PCHK;
          end
        end
        S_PCHK: begin
          // off-map player or empty map
          if (w_eff == 7'd0 || h_eff == 7'd0 || out_of_map) begin
            res_dist <= depth_limit;
            res_side <= 1'b0;
            res_kind <= dgrc_pkg::KIND_LIMITED;
            state    <= S_OUT;
          end else begin
            state <= S_PWALL;
          end
        end
        S_PWALL: begin
          adx     <= dirx_mag;
          ady     <= diry_mag;
          negx    <= dirx_neg && (dirx_mag != 15'd0);
          negy    <= diry_neg && (diry_mag != 15'd0);
          div_q   <= 32'h4000_0000;
          div_r   <= '0;
          div_d   <= dirx_mag;
          div_cnt <= '0;
          if (wall_rd) begin
            res_dist <= '0;
            res_side <= 1'b0;
            res_kind <= dgrc_pkg::KIND_INSIDE;
            state    <= S_OUT;
          end else begin
            state <= S_DIVX;
          end
        end
        S_DIVX, S_DIVY, S_DIVP: begin
          if (div_cnt == 5'd31) begin
            div_q   <= 32'h4000_0000;
            div_r   <= '0;
            div_d   <= ady;
            div_cnt <= '0;
            if (state == S_DIVX) begin
              ddx   <= (adx == 15'd0) ? dgrc_pkg::DELTA_SAT : {16'd0, q_final[30:0]};
              state <= S_DIVY;
            end else if (state == S_DIVY) begin
              ddy   <= (ady == 15'd0) ? dgrc_pkg::DELTA_SAT : {16'd0, q_final[30:0]};
              state <= S_SIDEX;
            end else begin
              res_side <= side;
              if (q_final > {16'd0, depth_limit}) begin
                res_dist <= depth_limit;
                res_kind <= dgrc_pkg::KIND_LIMITED;
              end else begin
                res_dist <= q_final[15:0];
                res_kind <= dgrc_pkg::KIND_HIT;
              end
              state <= S_OUT;
            end
          end else begin
            div_q   <= q_final;
            div_r   <= div_ge ? rem_sub[15:0] : rem_sh[15:0];
            div_cnt <= div_cnt + 5'd1;
          end
        end
        S_SIDEX: begin
          sdx   <= side_init;
          state <= S_SIDEY;
        end
        S_SIDEY: begin
          sdy      <= side_init;
          step_cnt <= '0;
          side     <= 1'b0;
          state    <= S_STEP;
        end
        S_STEP: begin
          // advance along the nearer grid line
          step_cnt <= step_cnt + 8'd1;
          if (sdx < sdy) begin
            sdx  <= sdx + {9'd0, ddx};
            mx   <= negx ? mx - 8'sd1 : mx + 8'sd1;
            side <= 1'b0;
          end else begin
            sdy  <= sdy + {9'd0, ddy};
            my   <= negy ? my - 8'sd1 : my + 8'sd1;
            side <= 1'b1;
          end
          state <= S_BCHK;
        end
        S_BCHK: begin
          if (out_of_map) begin
            res_dist <= depth_limit;
            res_side <= side;
            res_kind <= dgrc_pkg::KIND_LIMITED;
            state    <= S_OUT;
          end else begin
            state <= S_WCHK;
          end
        end
        S_WCHK: begin
          div_q   <= 32'({num, 14'd0});
          div_r   <= '0;
          div_d   <= adir;
          div_cnt <= '0;
          if (wall_rd && adir != 15'd0) begin
            state <= S_DIVP;
          end else if (wall_rd || step_cnt == 8'(dgrc_pkg::MAX_STEPS)) begin
            res_dist <= depth_limit;
            res_side <= side;
            res_kind <= dgrc_pkg::KIND_LIMITED;
            state    <= S_OUT;
          end else begin
            state <= S_STEP;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tdata  <= res_dist;
            m_tuser  <= {res_kind, res_side};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A started-in-wall result carries zero distance
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2:1] == dgrc_pkg::KIND_INSIDE |-> m_tdata == 16'd0)
    else $error("inside-wall result with nonzero distance");

  // A wall hit never exceeds the depth limit
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2:1] == dgrc_pkg::KIND_HIT |-> m_tdata <= depth_limit)
    else $error("hit distance above depth limit");

  // No item is taken while the map is being cleared
  assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !s_tready)
    else $error("item accepted during map clear");

  // A loaded result follows the output state
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_OUT)
    else $error("result loaded outside output state");

endmodule
